// ===== src/btbb_pkg.sv =====
// Shared types and constants for the binary threshold / bounding box block.
// No dependencies; used by every module of the block.
package btbb_pkg;

   // Fixed field widths
   localparam int PIXEL_W    = 8;
   localparam int BOX_W      = 12;
   localparam int SIZE_W     = 12;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 12;

   // Default frame limits
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   // Register reset values
   localparam logic [PIXEL_W-1:0] THRESHOLD_RESET = 8'd127;
   localparam logic [PIXEL_W-1:0] SET_VALUE_RESET = 8'd255;
   localparam logic [SIZE_W-1:0]  WIDTH_RESET     = 12'd640;
   localparam logic [SIZE_W-1:0]  HEIGHT_RESET    = 12'd480;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_SET_VALUE = 2'd1,
      CSR_WIDTH     = 2'd2,
      CSR_HEIGHT    = 2'd3
   } csr_index_type;

   // Frame-end report from the tracker
   typedef struct packed {
      logic             frame_done;
      logic [BOX_W-1:0] left;
      logic [BOX_W-1:0] top;
      logic [BOX_W-1:0] right;
      logic [BOX_W-1:0] bottom;
   } box_type;

endpackage

// ===== src/btbb_csr.sv =====
// Configuration registers and effective frame bounds.
// Depends on btbb_pkg.
module btbb_csr #(
   parameter int MAX_WIDTH  = btbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = btbb_pkg::DEF_MAX_HEIGHT,
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [btbb_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [btbb_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output logic [btbb_pkg::PIXEL_W-1:0]      threshold,
   output logic [btbb_pkg::PIXEL_W-1:0]      set_value,
   output logic [CW-1:0]                     last_col,
   output logic [RW-1:0]                     last_row
);

   logic [btbb_pkg::PIXEL_W-1:0] threshold_ff, threshold_in;
   logic [btbb_pkg::PIXEL_W-1:0] set_value_ff, set_value_in;
   logic [btbb_pkg::SIZE_W-1:0]  width_ff, width_in;
   logic [btbb_pkg::SIZE_W-1:0]  height_ff, height_in;

   // Register write decode
   always_comb begin
      threshold_in = threshold_ff;
      set_value_in = set_value_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            btbb_pkg::CSR_THRESHOLD: threshold_in = csr_write_data[btbb_pkg::PIXEL_W-1:0];
            btbb_pkg::CSR_SET_VALUE: set_value_in = csr_write_data[btbb_pkg::PIXEL_W-1:0];
            btbb_pkg::CSR_WIDTH:     width_in     = csr_write_data[btbb_pkg::SIZE_W-1:0];
            btbb_pkg::CSR_HEIGHT:    height_in    = csr_write_data[btbb_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= btbb_pkg::THRESHOLD_RESET;
         set_value_ff <= btbb_pkg::SET_VALUE_RESET;
         width_ff     <= btbb_pkg::WIDTH_RESET;
         height_ff    <= btbb_pkg::HEIGHT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         set_value_ff <= set_value_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   // Last column/row index: size 0 acts as 1, oversize saturates to the limit
   always_comb begin
      if (width_ff == '0)
         last_col = '0;
      else if (32'(width_ff) > MAX_WIDTH)
         last_col = CW'(MAX_WIDTH - 1);
      else
         last_col = CW'(width_ff - 1'b1);

      if (height_ff == '0)
         last_row = '0;
      else if (32'(height_ff) > MAX_HEIGHT)
         last_row = RW'(MAX_HEIGHT - 1);
      else
         last_row = RW'(height_ff - 1'b1);
   end

   assign threshold = threshold_ff;
   assign set_value = set_value_ff;

endmodule

// ===== src/btbb_track.sv =====
// Raster position counters and nonzero-pixel extent tracking.
// Depends on btbb_pkg (box_type, BOX_W).
module btbb_track #(
   parameter int MAX_WIDTH  = btbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = btbb_pkg::DEF_MAX_HEIGHT,
   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                hit,
   input  logic [CW-1:0]       last_col,
   input  logic [RW-1:0]       last_row,
   output btbb_pkg::box_type   box
);

   localparam int BW = btbb_pkg::BOX_W;

   logic [CW-1:0] col_ff, col_in, lc_ff, lc_in, gc_ff, gc_in;
   logic [RW-1:0] row_ff, row_in, lr_ff, lr_in, gr_ff, gr_in;
   logic          seen_ff, seen_in;
   logic          row_end, last_r, frame_end;
   logic [CW-1:0] lc_n, gc_n;
   logic [RW-1:0] lr_n, gr_n;
   logic          seen_n;

   assign row_end   = (col_ff >= last_col);
   assign last_r    = (row_ff >= last_row);
   assign frame_end = row_end && last_r;

   // Extent including the current pixel
   always_comb begin
      seen_n = seen_ff;
      lc_n   = lc_ff;
      gc_n   = gc_ff;
      lr_n   = lr_ff;
      gr_n   = gr_ff;
      if (hit) begin
         seen_n = 1'b1;
         if (!seen_ff) begin
            lc_n = col_ff;
            gc_n = col_ff;
            lr_n = row_ff;
            gr_n = row_ff;
         end else begin
            if (col_ff < lc_ff) lc_n = col_ff;
            if (col_ff > gc_ff) gc_n = col_ff;
            if (row_ff < lr_ff) lr_n = row_ff;
            if (row_ff > gr_ff) gr_n = row_ff;
         end
      end
   end

   // Box report: frame_done on a frame end; box fields zero except on a frame end with a nonzero pixel
   always_comb begin
      box            = '0;
      box.frame_done = frame_end;
      if (frame_end && seen_n) begin
         box.left   = BW'(lc_n);
         box.top    = BW'(lr_n);
         box.right  = BW'({1'b0, gc_n} + 1'b1);
         box.bottom = BW'({1'b0, gr_n} + 1'b1);
      end
   end

   // Next state
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      seen_in = seen_ff;
      lc_in   = lc_ff;
      gc_in   = gc_ff;
      lr_in   = lr_ff;
      gr_in   = gr_ff;
      if (step) begin
         if (frame_end) begin
            col_in  = '0;
            row_in  = '0;
            seen_in = 1'b0;
            lc_in   = '0;
            gc_in   = '0;
            lr_in   = '0;
            gr_in   = '0;
         end else begin
            seen_in = seen_n;
            lc_in   = lc_n;
            gc_in   = gc_n;
            lr_in   = lr_n;
            gr_in   = gr_n;
            if (row_end) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         seen_ff <= 1'b0;
         lc_ff   <= '0;
         gc_ff   <= '0;
         lr_ff   <= '0;
         gr_ff   <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         seen_ff <= seen_in;
         lc_ff   <= lc_in;
         gc_ff   <= gc_in;
         lr_ff   <= lr_in;
         gr_ff   <= gr_in;
      end
   end

endmodule

// ===== src/binary_threshold_with_bounding_box.sv =====
// Throughput: one pixel per cycle while rsp_stall is low; input register feeds
// threshold and tracking logic, which feeds the result register, and an accepted
// input reaches rsp_* through both. req_stall rises only while both stages hold
// data and rsp_stall is high.
// Reset (synchronous): empties both stages, loads register defaults, clears tracking.
// Depends on btbb_pkg, btbb_csr, btbb_track.
module binary_threshold_with_bounding_box #(
   parameter int MAX_WIDTH  = btbb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = btbb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [btbb_pkg::PIXEL_W-1:0]    req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [btbb_pkg::PIXEL_W-1:0]    rsp_pixel_out,
   output logic                            rsp_frame_done,
   output logic [btbb_pkg::BOX_W-1:0]      rsp_box_left,
   output logic [btbb_pkg::BOX_W-1:0]      rsp_box_top,
   output logic [btbb_pkg::BOX_W-1:0]      rsp_box_right,
   output logic [btbb_pkg::BOX_W-1:0]      rsp_box_bottom,
   input  logic                            csr_write_enable,
   input  logic [btbb_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [btbb_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [btbb_pkg::PIXEL_W-1:0] threshold, set_value;
   logic [CW-1:0]                last_col;
   logic [RW-1:0]                last_row;

   logic                         in_valid_ff, in_valid_in;
   logic [btbb_pkg::PIXEL_W-1:0] in_pixel_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [btbb_pkg::PIXEL_W-1:0] out_pixel_ff, pixel_res;
   btbb_pkg::box_type            out_box_ff, box;
   logic                         advance, take;

   btbb_csr #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .threshold        (threshold),
      .set_value        (set_value),
      .last_col         (last_col),
      .last_row         (last_row)
   );

   // Handshake: input stage moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // Threshold
   assign pixel_res = (in_pixel_ff > threshold) ? set_value : '0;

   btbb_track #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_track (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .hit      (pixel_res != '0),
      .last_col (last_col),
      .last_row (last_row),
      .box      (box)
   );

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take) in_pixel_ff <= req_pixel_in;
      if (advance) begin
         out_pixel_ff <= pixel_res;
         out_box_ff   <= box;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = out_pixel_ff;
   assign rsp_frame_done = out_box_ff.frame_done;
   assign rsp_box_left   = out_box_ff.left;
   assign rsp_box_top    = out_box_ff.top;
   assign rsp_box_right  = out_box_ff.right;
   assign rsp_box_bottom = out_box_ff.bottom;

endmodule

// ===== src/btbb_checker.sv =====
// Port-level checks for binary_threshold_with_bounding_box, plus its bind.
// Depends on btbb_pkg for field widths.
module btbb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [btbb_pkg::PIXEL_W-1:0] rsp_pixel_out,
   input logic                         rsp_frame_done,
   input logic [btbb_pkg::BOX_W-1:0]   rsp_box_left,
   input logic [btbb_pkg::BOX_W-1:0]   rsp_box_top,
   input logic [btbb_pkg::BOX_W-1:0]   rsp_box_right,
   input logic [btbb_pkg::BOX_W-1:0]   rsp_box_bottom
);

   // Box fields are zero on every pixel that does not end a frame
   a_box_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |->
         rsp_box_left == '0 && rsp_box_top == '0 &&
         rsp_box_right == '0 && rsp_box_bottom == '0)
      else $error("box fields nonzero outside frame end");

   // Input only backs up when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // Nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out) &&
         $stable(rsp_frame_done))
      else $error("stalled result changed");

endmodule

bind binary_threshold_with_bounding_box btbb_checker u_btbb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pixel_out  (rsp_pixel_out),
   .rsp_frame_done (rsp_frame_done),
   .rsp_box_left   (rsp_box_left),
   .rsp_box_top    (rsp_box_top),
   .rsp_box_right  (rsp_box_right),
   .rsp_box_bottom (rsp_box_bottom)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for binary_threshold_with_bounding_box: thresholding,
// raster tracking and frame-end bounding box under random stalls on both channels.
// Depends on btbb_pkg and the RTL of the block; nothing else.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW          = btbb_pkg::PIXEL_W;
   localparam int BW          = btbb_pkg::BOX_W;
   localparam int SW          = btbb_pkg::SIZE_W;
   localparam int AW          = btbb_pkg::CSR_ADDR_W;
   localparam int DW          = btbb_pkg::CSR_DATA_W;
   localparam int QUIET_LIMIT = 2000;   // cycles with no transaction before giving up
   localparam int LONG_HOLD   = 200;    // receiver hold-off for the pressure test
   localparam int LONG_ROW    = 400;    // pixels sent on the wide row before shrinking
   localparam int FRAME_MAX_W = btbb_pkg::DEF_MAX_WIDTH;
   localparam int FRAME_MAX_H = btbb_pkg::DEF_MAX_HEIGHT;

   // Predicted result transaction
   typedef struct packed {
      logic [PW-1:0] pixel_out;
      logic          frame_done;
      logic [BW-1:0] left;
      logic [BW-1:0] top;
      logic [BW-1:0] right;
      logic [BW-1:0] bottom;
   } pixel_box_type;

   // Pixel content shapes for random stimulus
   typedef enum int {
      PIX_UNIFORM,
      PIX_NEAR_LEVEL,
      PIX_EXTREME,
      PIX_SPARSE
   } pixel_mode_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [PW-1:0] req_pixel_in = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [PW-1:0] rsp_pixel_out;
   logic          rsp_frame_done;
   logic [BW-1:0] rsp_box_left;
   logic [BW-1:0] rsp_box_top;
   logic [BW-1:0] rsp_box_right;
   logic [BW-1:0] rsp_box_bottom;
   logic          csr_write_enable = 1'b0;
   logic [AW-1:0] csr_index = '0;
   logic [DW-1:0] csr_write_data = '0;

   // Predictor copy of the registers and the tracking state
   logic [PW-1:0] cfg_threshold = btbb_pkg::THRESHOLD_RESET;
   logic [PW-1:0] cfg_set       = btbb_pkg::SET_VALUE_RESET;
   logic [SW-1:0] cfg_width     = btbb_pkg::WIDTH_RESET;
   logic [SW-1:0] cfg_height    = btbb_pkg::HEIGHT_RESET;
   int            col_pos = 0;
   int            row_pos = 0;
   bit            seen_set = 1'b0;
   int            min_col = 0;
   int            max_col = 0;
   int            min_row = 0;
   int            max_row = 0;

   pixel_box_type predicted_pixels[$];
   int            error_count = 0;
   int            pixels_sent = 0;
   int            quiet_cycles = 0;
   bit            tx_idle_on = 1'b0;
   bit            rx_idle_on = 1'b0;
   bit            long_hold_request = 1'b0;

   binary_threshold_with_bounding_box dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_in     (req_pixel_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_box_left     (rsp_box_left),
      .rsp_box_top      (rsp_box_top),
      .rsp_box_right    (rsp_box_right),
      .rsp_box_bottom   (rsp_box_bottom),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Zero acts as one, oversize saturates
   function automatic int eff_size(input logic [SW-1:0] v, input int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   // Threshold one pixel, advance the raster position, report the box at frame end
   function automatic pixel_box_type binarize_and_track(input logic [PW-1:0] pix);
      pixel_box_type r;
      int            w;
      int            h;
      logic [PW-1:0] level;
      bit            row_end;
      bit            last_row;
      w = eff_size(cfg_width, FRAME_MAX_W);
      h = eff_size(cfg_height, FRAME_MAX_H);
      level = (pix > cfg_threshold) ? cfg_set : '0;
      row_end = (col_pos >= w - 1);
      last_row = (row_pos >= h - 1);
      r = '0;
      r.pixel_out = level;
      if (level != 0) begin
         if (!seen_set) begin
            min_col = col_pos;
            max_col = col_pos;
            min_row = row_pos;
            max_row = row_pos;
            seen_set = 1'b1;
         end else begin
            if (col_pos < min_col) min_col = col_pos;
            if (col_pos > max_col) max_col = col_pos;
            if (row_pos < min_row) min_row = row_pos;
            if (row_pos > max_row) max_row = row_pos;
         end
      end
      if (row_end && last_row) begin
         r.frame_done = 1'b1;
         if (seen_set) begin
            r.left   = BW'(min_col);
            r.top    = BW'(min_row);
            r.right  = BW'(max_col + 1);
            r.bottom = BW'(max_row + 1);
         end
         col_pos = 0;
         row_pos = 0;
         seen_set = 1'b0;
         min_col = 0;
         max_col = 0;
         min_row = 0;
         max_row = 0;
      end else if (row_end) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return r;
   endfunction

   // Pixels still needed to reach the end of the current frame
   function automatic int frame_pixels_left();
      int w;
      int h;
      int rows_left;
      int cols_left;
      w = eff_size(cfg_width, FRAME_MAX_W);
      h = eff_size(cfg_height, FRAME_MAX_H);
      rows_left = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
      cols_left = (col_pos >= w - 1) ? 0 : w - 1 - col_pos;
      return rows_left * w + cols_left + 1;
   endfunction

   function automatic logic [PW-1:0] pick_pixel(input pixel_mode_type mode);
      int v;
      case (mode)
         PIX_NEAR_LEVEL: begin
            v = int'(cfg_threshold) + int'($urandom_range(0, 2)) - 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         PIX_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
         PIX_SPARSE: v = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 255)) : 0;
         default: v = int'($urandom_range(0, 255));
      endcase
      return PW'(v);
   endfunction

   // Mostly small sizes, now and then zero
   function automatic logic [SW-1:0] random_size(input int largest);
      if ($urandom_range(0, 9) == 0) return '0;
      return SW'($urandom_range(1, largest));
   endfunction

   task automatic check_field(input string name, input logic [BW-1:0] want,
                              input logic [BW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Register write; the predictor copy follows the same masking
   task automatic write_csr(input btbb_pkg::csr_index_type idx, input logic [DW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         btbb_pkg::CSR_THRESHOLD: cfg_threshold = data[PW-1:0];
         btbb_pkg::CSR_SET_VALUE: cfg_set = data[PW-1:0];
         btbb_pkg::CSR_WIDTH:     cfg_width = data[SW-1:0];
         btbb_pkg::CSR_HEIGHT:    cfg_height = data[SW-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic program_frame(input logic [PW-1:0] level, input logic [PW-1:0] value,
                                input logic [SW-1:0] w, input logic [SW-1:0] h);
      write_csr(btbb_pkg::CSR_THRESHOLD, DW'(level));
      write_csr(btbb_pkg::CSR_SET_VALUE, DW'(value));
      write_csr(btbb_pkg::CSR_WIDTH, DW'(w));
      write_csr(btbb_pkg::CSR_HEIGHT, DW'(h));
   endtask

   // Offer one pixel transaction, with an optional idle burst ahead of it
   task automatic send_pixel(input logic [PW-1:0] pix);
      int gap;
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic send_pixels(input int count, input pixel_mode_type mode);
      repeat (count) send_pixel(pick_pixel(mode));
   endtask

   // Stop offering and wait until every predicted result has come back
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_pixels.size() != 0) @(posedge clock);
   endtask

   // Register defaults right after reset, then close the frame with a 1x1 size
   task automatic test_reset_defaults();
      send_pixel(8'd127);
      send_pixel(8'd128);
      send_pixel(8'd0);
      send_pixel(8'd255);
      settle_pipeline();
      program_frame(btbb_pkg::THRESHOLD_RESET, btbb_pkg::SET_VALUE_RESET, 12'd1, 12'd1);
      send_pixel(8'd0);
      settle_pipeline();
   endtask

   // Threshold at both ends of its range
   task automatic test_threshold_extremes();
      program_frame(8'd0, 8'd255, 12'd3, 12'd2);
      send_pixel(8'd0);
      send_pixel(8'd1);
      send_pixel(8'd0);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      settle_pipeline();
      program_frame(8'd255, 8'd200, 12'd3, 12'd2);
      send_pixel(8'd255);
      send_pixel(8'd254);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd255);
      send_pixel(8'd128);
      settle_pipeline();
   endtask

   // Set value of zero gives an empty box; smallest nonzero set value
   task automatic test_set_value_zero();
      program_frame(8'd10, 8'd0, 12'd2, 12'd1);
      send_pixel(8'd200);
      send_pixel(8'd255);
      settle_pipeline();
      write_csr(btbb_pkg::CSR_SET_VALUE, 12'd1);
      send_pixel(8'd11);
      send_pixel(8'd10);
      settle_pipeline();
   endtask

   // Width and height of zero act as one pixel frames
   task automatic test_degenerate_sizes();
      program_frame(8'd127, 8'd255, 12'd0, 12'd0);
      send_pixel(8'd255);
      send_pixel(8'd0);
      settle_pipeline();
   endtask

   // Oversized sizes, then shrinking them while the position is past the new bounds
   task automatic test_size_change_mid_frame();
      program_frame(8'd127, 8'd255, 12'hFFF, 12'hFFF);
      send_pixel(8'd0);
      send_pixel(8'd200);
      send_pixel(8'd0);
      settle_pipeline();
      write_csr(btbb_pkg::CSR_WIDTH, 12'd2);
      send_pixel(8'd0);
      settle_pipeline();
      write_csr(btbb_pkg::CSR_HEIGHT, 12'd1);
      send_pixel(8'd255);
      send_pixel(8'd0);
      settle_pipeline();
   endtask

   // Receiver holds off long enough that the block fills and stalls its input
   task automatic test_backpressure();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      program_frame(8'd127, 8'd200, 12'd5, 12'd4);
      long_hold_request = 1'b1;
      send_pixels(20, PIX_UNIFORM);
      settle_pipeline();
   endtask

   // Long row at the saturated width, closed by shrinking the width to one
   task automatic test_saturated_row();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      program_frame(8'd100, 8'd255, 12'hFFF, 12'd1);
      send_pixel(8'd255);
      send_pixels(LONG_ROW - 2, PIX_SPARSE);
      send_pixel(8'd255);
      settle_pipeline();
      write_csr(btbb_pkg::CSR_WIDTH, 12'd1);
      send_pixel(8'd0);
      settle_pipeline();
   endtask

   // Random frames with random registers, some resized partway through
   task automatic test_random_frames(input int item_goal, input bit idling);
      int             stop_at;
      int             left;
      int             split;
      logic [3:0]     pad;
      logic [PW-1:0]  level;
      logic [PW-1:0]  value;
      pixel_mode_type mode;
      stop_at = pixels_sent + item_goal;
      while (pixels_sent < stop_at) begin
         tx_idle_on = idling && ($urandom_range(0, 3) != 0);
         rx_idle_on = idling && ($urandom_range(0, 3) != 0);
         mode = pixel_mode_type'($urandom_range(0, 3));
         level = PW'($urandom_range(0, 255));
         case ($urandom_range(0, 7))
            0: level = 8'd0;
            1: level = 8'd255;
            default: ;
         endcase
         value = PW'($urandom_range(0, 255));
         case ($urandom_range(0, 7))
            0: value = 8'd0;
            1: value = 8'd255;
            default: ;
         endcase
         // upper data bits are don't-care for the 8-bit registers
         pad = 4'($urandom_range(0, 15));
         write_csr(btbb_pkg::CSR_THRESHOLD, {pad, level});
         pad = 4'($urandom_range(0, 15));
         write_csr(btbb_pkg::CSR_SET_VALUE, {pad, value});
         write_csr(btbb_pkg::CSR_WIDTH, random_size(12));
         write_csr(btbb_pkg::CSR_HEIGHT, random_size(6));
         left = frame_pixels_left();
         if (left > 1 && $urandom_range(0, 3) == 0) begin
            split = $urandom_range(1, left - 1);
            send_pixels(split, mode);
            settle_pipeline();
            write_csr(btbb_pkg::CSR_WIDTH, random_size(12));
            write_csr(btbb_pkg::CSR_HEIGHT, random_size(6));
            left = frame_pixels_left();
         end
         send_pixels(left, mode);
         settle_pipeline();
      end
   endtask

   // Receiver: random stall bursts, plus one long hold on request
   initial begin : rsp_driver
      int gap;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Predict on each accepted pixel, compare each accepted result
   always @(posedge clock) begin : scoreboard
      pixel_box_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            predicted_pixels.push_back(binarize_and_track(req_pixel_in));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_pixels.size() == 0) begin
               $error("result transaction with no prediction pending");
               error_count++;
            end else begin
               want = predicted_pixels.pop_front();
               check_field("pixel_out", BW'(want.pixel_out), BW'(rsp_pixel_out));
               check_field("frame_done", BW'(want.frame_done), BW'(rsp_frame_done));
               check_field("box_left", want.left, rsp_box_left);
               check_field("box_top", want.top, rsp_box_top);
               check_field("box_right", want.right, rsp_box_right);
               check_field("box_bottom", want.bottom, rsp_box_bottom);
            end
         end
      end
   end

   // Watchdog on stretches with no transaction on either channel
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
   end

   initial begin : main
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      test_reset_defaults();
      test_threshold_extremes();
      test_set_value_zero();
      test_degenerate_sizes();
      test_size_change_mid_frame();
      test_backpressure();
      test_saturated_row();
      test_random_frames(950, 1'b1);
      // closing stretch runs without idling on either side
      test_random_frames(250, 1'b0);
      settle_pipeline();
      repeat (8) @(posedge clock);
      if (predicted_pixels.size() != 0) begin
         $error("%0d predicted results never arrived", predicted_pixels.size());
         error_count++;
      end
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
